>>> sv/mchb_pkg.sv
`default_nettype none

package mchb_pkg;

  // Default channel capacity and fixed field widths
  localparam int unsigned NumChannelsDef = 4;
  localparam int unsigned TimeW          = 32;
  localparam int unsigned ChanW          = 2;
  localparam int unsigned CountW         = 3;
  localparam int unsigned CfgIdxW        = 3;

  // Operation codes of an input word
  localparam logic OP_HEARTBEAT = 1'b0;
  localparam logic OP_CHECK     = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_CH0   = 3'd1;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  // Event waiting for its successor to settle the last flag
  typedef struct packed {
    logic             valid;
    logic [ChanW-1:0] chan;
    logic             is_dead;
    logic             changed;
  } pend_t;

endpackage

`default_nettype wire

>>> sv/multi_channel_heartbeat_monitor.sv
// Heartbeat: taken while idle, busy_o stays low, no result word. No receiver stall.
// Health check over n active channels: busy through the walk (one channel per cycle
// through the shared subtract/compare unit) and a flush state, so a new check is taken
// only once idle; with n = 0 it is taken like a heartbeat. An event word waits for the
// next event or the flush, so the last word is valid in the cycle after the flush.
// Reset (async, active low) clears channel count, timeouts and channel state.
`default_nettype none

module multi_channel_heartbeat_monitor
  import mchb_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Command side
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic               operation_i,
  input  wire logic [ChanW-1:0]   channel_i,
  input  wire logic [TimeW-1:0]   now_ms_i,
  // Configuration write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [TimeW-1:0]   cfg_data_i,
  // Result side
  output logic                    out_valid_o,
  output logic [ChanW-1:0]        event_channel_o,
  output logic                    is_dead_o,
  output logic                    changed_o,
  output logic                    last_o
);

  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  state_e                   state_q, state_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic [TimeW-1:0]         now_q, now_d;
  pend_t                    pend_q, pend_d;
  logic [CountW-1:0]        count_q;
  logic [TimeW-1:0]         timeout_q   [NUM_CHANNELS];
  logic [TimeW-1:0]         last_seen_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  ever_q;
  logic [NUM_CHANNELS-1:0]  alive_q;

  logic                     out_valid_q, out_valid_d;
  logic [ChanW-1:0]         out_chan_q, out_chan_d;
  logic                     out_dead_q, out_dead_d;
  logic                     out_chg_q, out_chg_d;
  logic                     out_last_q, out_last_d;

  logic [CountW-1:0]        active_n;
  logic                     accept;
  logic                     hb_accept;
  logic [TimeW-1:0]         age;
  logic                     now_alive;
  logic                     trans;
  logic                     evt;
  logic                     walk_end;

  // Clamp the channel count to the built capacity
  assign active_n = (count_q > CountW'(NUM_CHANNELS)) ? CountW'(NUM_CHANNELS) : count_q;

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign hb_accept   = accept && (operation_i == OP_HEARTBEAT) &&
                       ({1'b0, channel_i} < active_n);

  // Shared unit: age of the current channel against its timeout
  assign age       = now_q - last_seen_q[idx_q];
  assign now_alive = ever_q[idx_q] && (age < timeout_q[idx_q]);
  assign trans     = (now_alive != alive_q[idx_q]);
  assign evt       = !now_alive || trans;
  assign walk_end  = (CountW'(idx_q) == active_n - CountW'(1));

  // Sequencer and result staging
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    now_d       = now_q;
    pend_d      = pend_q;
    out_valid_d = 1'b0;
    out_chan_d  = out_chan_q;
    out_dead_d  = out_dead_q;
    out_chg_d   = out_chg_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == OP_CHECK) && (active_n != '0)) begin
          state_d      = ST_WALK;
          idx_d        = '0;
          now_d        = now_ms_i;
          pend_d.valid = 1'b0;
        end
      end
      ST_WALK: begin
        if (evt) begin
          // Release the held event; a newer one follows it
          if (pend_q.valid) begin
            out_valid_d = 1'b1;
            out_chan_d  = pend_q.chan;
            out_dead_d  = pend_q.is_dead;
            out_chg_d   = pend_q.changed;
            out_last_d  = 1'b0;
          end
          pend_d.valid   = 1'b1;
          pend_d.chan    = ChanW'(idx_q);
          pend_d.is_dead = !now_alive;
          pend_d.changed = trans;
        end
        if (walk_end) begin
          state_d = ST_FLUSH;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_FLUSH: begin
        // Held event is the final one of this check
        if (pend_q.valid) begin
          out_valid_d = 1'b1;
          out_chan_d  = pend_q.chan;
          out_dead_d  = pend_q.is_dead;
          out_chg_d   = pend_q.changed;
          out_last_d  = 1'b1;
        end
        pend_d.valid = 1'b0;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control, configuration and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      count_q      <= '0;
      ever_q       <= '0;
      alive_q      <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        timeout_q[c]   <= '0;
        last_seen_q[c] <= '0;
      end
    end else begin
      state_q      <= state_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
      // Register writes
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_CHANNEL_COUNT) begin
          count_q <= cfg_data_i[CountW-1:0];
        end
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (cfg_index_i == REG_TIMEOUT_CH0 + CfgIdxW'(c)) begin
            timeout_q[c] <= cfg_data_i;
          end
        end
      end
      // Record a heartbeat
      if (hb_accept) begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (channel_i == ChanW'(c)) begin
            last_seen_q[c] <= now_ms_i;
            ever_q[c]      <= 1'b1;
          end
        end
      end
      // Update the alive flag of the walked channel
      if (state_q == ST_WALK) begin
        alive_q[idx_q] <= now_alive;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q          <= idx_d;
    now_q          <= now_d;
    out_chan_q     <= out_chan_d;
    out_dead_q     <= out_dead_d;
    out_chg_q      <= out_chg_d;
    out_last_q     <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign event_channel_o = out_chan_q;
  assign is_dead_o       = out_dead_q;
  assign changed_o       = out_chg_q;
  assign last_o          = out_last_q;

endmodule

`default_nettype wire
